// ----- rtl/scfp_pkg.sv -----
// scfp_pkg: shared types, limits and keyword tables of the serial command frame parser
// no dependencies
`default_nettype none

package scfp_pkg;

  // limits
  localparam int MaxFrame  = 128;
  localparam int MaxFields = 8;
  localparam int PathLimit = 32;

  localparam logic [7:0] MAX_FRAME_B  = 8'(MaxFrame);
  localparam logic [3:0] FIELD_SAT    = 4'(MaxFields - 1);
  localparam logic [5:0] PATH_LIMIT_B = 6'(PathLimit);

  // special byte codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // keyword tables, listen in entry 0 up to reply in entry 4
  localparam int KwCount = 5;
  localparam int KwSpan  = 8;

  localparam logic [7:0] KW_TEXT [KwCount][KwSpan] = '{
    '{8'h4C, 8'h49, 8'h53, 8'h54, 8'h45, 8'h4E, 8'h00, 8'h00},  // LISTEN
    '{8'h50, 8'h4F, 8'h4C, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00},  // POLL
    '{8'h41, 8'h52, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // ARG
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h41, 8'h52, 8'h47, 8'h00},  // POSTARG
    '{8'h52, 8'h45, 8'h50, 8'h4C, 8'h59, 8'h00, 8'h00, 8'h00}   // REPLY
  };
  localparam logic [3:0] KW_LEN [KwCount]       = '{4'd6, 4'd4, 4'd3, 4'd7, 4'd5};
  localparam logic [3:0] KW_SHAPE [KwCount]     = '{4'd2, 4'd1, 4'd2, 4'd2, 4'd3};
  localparam logic [2:0] KW_CMD_CODE [KwCount]  = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
  localparam int         KwListen = 0;

  // command codes
  localparam logic [2:0] CMD_NONE = 3'd0;

  typedef enum logic [1:0] {
    KIND_OOB   = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_END   = 2'd2,
    KIND_ABORT = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [2:0] command;
    logic [3:0] field_total;
    logic       shape_ok;
  } result_t;

  // per-frame running state
  typedef struct packed {
    logic       in_frame;
    logic [7:0] frame_length;
    logic [3:0] field_index;
    logic [3:0] first_position;
    logic [4:0] keyword_hits;
    logic [5:0] second_length;
  } frame_state_t;

  localparam frame_state_t FRAME_STATE_RST = '{
    in_frame:       1'b0,
    frame_length:   8'd0,
    field_index:    4'd0,
    first_position: 4'd0,
    keyword_hits:   5'h1F,
    second_length:  6'd0
  };

endpackage

`default_nettype wire

// ----- rtl/scfp_parser.sv -----
// scfp_parser: frame state register and per-byte decode
// depends on scfp_pkg
`default_nettype none

module scfp_parser (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   advance_i,
  input  wire  [7:0]            rx_byte_i,
  output logic                  has_result_o,
  output scfp_pkg::result_t     result_o
);
  import scfp_pkg::*;

  frame_state_t state_q, state_d;
  logic [2:0]   close_cmd;
  logic         close_ok;
  logic [3:0]   close_total;

  // keyword resolution at frame end, later entries win
  always_comb begin
    close_cmd   = CMD_NONE;
    close_ok    = 1'b0;
    close_total = state_q.field_index + 4'd1;
    for (int k = 0; k < KwCount; k++) begin
      if (state_q.keyword_hits[k] && (state_q.first_position == KW_LEN[k])) begin
        close_cmd = KW_CMD_CODE[k];
        close_ok  = (close_total == KW_SHAPE[k]);
        if ((k == KwListen) && (state_q.second_length >= PATH_LIMIT_B)) begin
          close_ok = 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    has_result_o = 1'b0;
    result_o     = '{kind: KIND_OOB, data: rx_byte_i, command: CMD_NONE,
                     field_total: 4'd0, shape_ok: 1'b0};
    if (!state_q.in_frame) begin
      if (rx_byte_i == CH_DOLLAR) begin
        state_d          = FRAME_STATE_RST;
        state_d.in_frame = 1'b1;
      end else begin
        has_result_o = 1'b1;
      end
    end else if (rx_byte_i == CH_LF) begin
      state_d.in_frame     = 1'b0;
      has_result_o         = 1'b1;
      result_o.kind        = KIND_END;
      result_o.data        = 8'd0;
      result_o.command     = close_cmd;
      result_o.field_total = close_total;
      result_o.shape_ok    = close_ok;
    end else if (rx_byte_i == CH_CR) begin
      // carriage return dropped
    end else if (state_q.frame_length < MAX_FRAME_B) begin
      state_d.frame_length = state_q.frame_length + 8'd1;
      has_result_o         = 1'b1;
      result_o.kind        = KIND_FRAME;
      if (rx_byte_i == CH_COMMA) begin
        if (state_q.field_index < FIELD_SAT) begin
          state_d.field_index = state_q.field_index + 4'd1;
        end
      end else if (state_q.field_index == 4'd0) begin
        for (int k = 0; k < KwCount; k++) begin
          if ((state_q.first_position >= KW_LEN[k]) ||
              (KW_TEXT[k][state_q.first_position[2:0]] != rx_byte_i)) begin
            state_d.keyword_hits[k] = 1'b0;
          end
        end
        if (state_q.first_position != 4'hF) begin
          state_d.first_position = state_q.first_position + 4'd1;
        end
      end else if (state_q.field_index == 4'd1) begin
        if (state_q.second_length != 6'h3F) begin
          state_d.second_length = state_q.second_length + 6'd1;
        end
      end
    end else begin
      // overlong frame
      state_d.in_frame = 1'b0;
      has_result_o     = 1'b1;
      result_o.kind    = KIND_ABORT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRAME_STATE_RST;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scfp_out_reg.sv -----
// scfp_out_reg: result register with valid/ready toward the consumer
// depends on scfp_pkg
`default_nettype none

module scfp_out_reg (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                load_i,
  input  scfp_pkg::result_t  result_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output scfp_pkg::result_t  result_o
);
  import scfp_pkg::*;

  logic    valid_q;
  result_t data_q;

  // register may take a new value when empty or being drained
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/serial_command_frame_parser_top.sv -----
// an accepted byte is held in the input register, then its result is loaded into the result
//   register that drives the output ports; a full result register can hold the byte back
// throughput: one item per cycle, with the input register and the result register
//   decoupling the two sides; stalls only while the result register is full and not taken
// bytes that give no result ('$' opening a frame, CR inside a frame) still take one slot
// reset: asynchronous active low; clears both valid flags and returns the parser
//   to outside-a-frame with all keywords still matching
`default_nettype none

module serial_command_frame_parser_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input channel
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  rx_byte_i,
  // output channel
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  command_o,
  output logic [3:0]  field_total_o,
  output logic        shape_ok_o
);
  import scfp_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  logic       out_free;
  logic       advance;
  logic       has_result;
  result_t    result;
  result_t    out_result;

  // the held item moves on when the result register can take it
  assign advance    = in_valid_q && out_free;
  // input register accepts when empty or emptying this cycle
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // frame state and decode; state moves only when the item advances
  scfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .rx_byte_i    (in_byte_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // result register; a byte with no result just empties the slot
  scfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign kind_o        = out_result.kind;
  assign out_byte_o    = out_result.data;
  assign command_o     = out_result.command;
  assign field_total_o = out_result.field_total;
  assign shape_ok_o    = out_result.shape_ok;

endmodule

`default_nettype wire

// ----- rtl/scfp_checker.sv -----
// scfp_checker: port-level assertions for the frame parser, bound to the top level
// depends on scfp_pkg and serial_command_frame_parser_top
`default_nettype none

module scfp_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_ready_o,
  input  wire        out_valid_o,
  input  wire        out_ready_i,
  input  wire  [1:0] kind_o,
  input  wire  [7:0] out_byte_o,
  input  wire  [2:0] command_o,
  input  wire  [3:0] field_total_o,
  input  wire        shape_ok_o
);
  import scfp_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(out_byte_o))
    else $error("result dropped while stalled");

  // only frame end carries a report
  a_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_END) |->
      (command_o == CMD_NONE) && (field_total_o == 4'd0) && !shape_ok_o)
    else $error("report fields set outside frame end");

  // frame end has a zero byte and at least one field
  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_END) |->
      (out_byte_o == 8'd0) && (field_total_o != 4'd0) && (command_o <= 3'd5))
    else $error("malformed frame end");

  // shape check only passes for a known command
  a_shape_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shape_ok_o |-> (command_o != CMD_NONE))
    else $error("shape ok without command");

  // input side is ready as soon as reset is released, while the pipeline is empty
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_ready_o)
    else $error("not ready after reset");

endmodule

bind serial_command_frame_parser_top scfp_checker u_scfp_checker (.*);

`default_nettype wire
